// ===== design/pbm_pkg.sv =====
package pbm_pkg;

    // Color channels handled side by side: red, green, blue
    localparam int LANES = 3;
    localparam int CH_W  = 8;

    // Blend mode codes
    localparam logic [1:0] MODE_NORMAL   = 2'd0;
    localparam logic [1:0] MODE_MULTIPLY = 2'd1;
    localparam logic [1:0] MODE_SCREEN   = 2'd2;
    localparam logic [1:0] MODE_OVERLAY  = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPACITY    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOUR = 8'd3;

    localparam logic [7:0] OPACITY_NONE = 8'd0;
    localparam logic [7:0] OPACITY_FULL = 8'd255;
    localparam logic [7:0] CH_MAX       = 8'd255;
    localparam logic [7:0] OVERLAY_SPLIT = 8'd128;

    // Stage load enables shared by all lanes
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_lane_ctl;

    // What one lane hands to the merging stage
    typedef struct packed {
        logic [7:0]  base;
        logic [7:0]  res;
        logic [16:0] base_prod;
        logic [16:0] res_prod;
    } t_lane_out;

endpackage

// ===== design/pbm_lane.sv =====
module pbm_lane
    import pbm_pkg::*;
(
    input  logic       i_clk,
    input  t_lane_ctl  i_ctl,
    input  logic [1:0] i_blend_mode,
    input  logic [7:0] i_opacity,
    input  logic [7:0] i_base,
    input  logic [7:0] i_top,
    output t_lane_out  o_lane
);

    // Stage 1: operand product
    logic [16:0] r1_x, n1_x;
    logic        r1_inv, n1_inv;
    logic        r1_byp, n1_byp;
    logic [7:0]  r1_b, r1_t;
    // Stage 2: quotient estimate
    logic [9:0]  r2_q0;
    logic [16:0] r2_x;
    logic        r2_inv, r2_byp;
    logic [7:0]  r2_b, r2_t;
    // Stage 3: mode result
    logic [7:0]  r3_res, n3_res;
    logic [7:0]  r3_b;
    // Stage 4: mix products
    logic [16:0] r4_bp, r4_rp;
    logic [7:0]  r4_b, r4_res;

    logic [7:0]  nb, nt;
    logic [15:0] prod_plain, prod_inv;
    logic [17:0] est_sum;
    logic [18:0] rem;
    logic [9:0]  q_fix;

    // Pick the product that the mode divides by 255
    always_comb begin
        nb         = CH_MAX - i_base;
        nt         = CH_MAX - i_top;
        prod_plain = i_base * i_top;
        prod_inv   = nb * nt;
        n1_x       = '0;
        n1_inv     = 1'b0;
        n1_byp     = 1'b0;
        unique case (i_blend_mode)
            MODE_NORMAL: begin
                n1_byp = 1'b1;
            end
            MODE_MULTIPLY: begin
                n1_x = {1'b0, prod_plain};
            end
            MODE_SCREEN: begin
                n1_x   = {1'b0, prod_inv};
                n1_inv = 1'b1;
            end
            default: begin
                if (i_base < OVERLAY_SPLIT) begin
                    n1_x = {prod_plain, 1'b0};
                end else begin
                    n1_x   = {prod_inv, 1'b0};
                    n1_inv = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1) begin
            r1_x   <= n1_x;
            r1_inv <= n1_inv;
            r1_byp <= n1_byp;
            r1_b   <= i_base;
            r1_t   <= i_top;
        end
    end

    // Estimate x/255 as (x + x/256 + 1)/256, off by at most one
    assign est_sum = {1'b0, r1_x} + {9'd0, r1_x[16:8]} + 18'd1;

    always_ff @(posedge i_clk) begin
        if (i_ctl.s2) begin
            r2_q0  <= est_sum[17:8];
            r2_x   <= r1_x;
            r2_inv <= r1_inv;
            r2_byp <= r1_byp;
            r2_b   <= r1_b;
            r2_t   <= r1_t;
        end
    end

    // Correct the estimate from the signed remainder, then apply the mode
    always_comb begin
        rem = {2'b00, r2_x} - ({1'b0, r2_q0, 8'd0} - {9'd0, r2_q0});
        if (rem[18]) begin
            q_fix = r2_q0 - 10'd1;
        end else if (rem >= 19'd255) begin
            q_fix = r2_q0 + 10'd1;
        end else begin
            q_fix = r2_q0;
        end
        if (r2_byp) begin
            n3_res = r2_t;
        end else if (r2_inv) begin
            n3_res = CH_MAX - q_fix[7:0];
        end else begin
            n3_res = q_fix[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s3) begin
            r3_res <= n3_res;
            r3_b   <= r2_b;
        end
    end

    // Weight base and mode result for the opacity mix
    always_ff @(posedge i_clk) begin
        if (i_ctl.s4) begin
            r4_bp  <= r3_b * (9'd256 - {1'b0, i_opacity});
            r4_rp  <= r3_res * ({1'b0, i_opacity} + 9'd1);
            r4_b   <= r3_b;
            r4_res <= r3_res;
        end
    end

    assign o_lane.base      = r4_b;
    assign o_lane.res       = r4_res;
    assign o_lane.base_prod = r4_bp;
    assign o_lane.res_prod  = r4_rp;

endmodule

// ===== design/pbm_merge.sv =====
module pbm_merge
    import pbm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [7:0]                 i_opacity,
    input  logic                       i_key_hit,
    input  t_lane_out [LANES-1:0]      i_lane,
    output logic [LANES-1:0][CH_W-1:0] o_pixel
);

    logic [LANES-1:0][CH_W-1:0] r_pixel, n_pixel;
    logic [LANES-1:0][9:0]      mix_sum;

    // Combine lane results: key pass-through, opacity ends, or mix
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            mix_sum[i] = {1'b0, i_lane[i].base_prod[16:8]}
                       + {1'b0, i_lane[i].res_prod[16:8]};
            if (i_key_hit || i_opacity == OPACITY_NONE) begin
                n_pixel[i] = i_lane[i].base;
            end else if (i_opacity == OPACITY_FULL) begin
                n_pixel[i] = i_lane[i].res;
            end else begin
                n_pixel[i] = mix_sum[i][7:0];
            end
        end
    end

    // Hold the finished pixel until it is taken
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_pixel = r_pixel;

endmodule

// ===== design/pixel_blend_mode_unit_top.sv =====
// Composites a foreground RGB888 pixel over a background pixel with a selectable
// blend mode (normal, multiply, screen, overlay), optional color keying and an
// opacity mix. One pixel request is taken per clock while the output is not
// stalled; the three color channels run in separate lanes of a five-stage
// pipeline (product, divide-by-255 estimate, correction, mix products, merge and
// output register), and a stalled output only holds the stages that are full, so
// empty stages keep taking new requests. Configuration writes are taken every
// cycle and must only be made while the pipeline is empty.
module pixel_blend_mode_unit_top
    import pbm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // Pixel request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_base_red,
    input  logic [7:0]           i_base_green,
    input  logic [7:0]           i_base_blue,
    input  logic [7:0]           i_top_red,
    input  logic [7:0]           i_top_green,
    input  logic [7:0]           i_top_blue,
    // Result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_out_red,
    output logic [7:0]           o_out_green,
    output logic [7:0]           o_out_blue
);

    logic [1:0]  r_blend_mode;
    logic [7:0]  r_opacity;
    logic        r_key_enable;
    logic [23:0] r_key_colour;

    logic [4:0]  r_valid, n_valid;
    logic [4:0]  stage_en;
    logic [3:0]  r_key_hit;
    logic        key_now;
    t_lane_ctl   lane_ctl;

    logic [LANES-1:0][CH_W-1:0] base_in, top_in;
    t_lane_out [LANES-1:0]      lane_out;
    logic [LANES-1:0][CH_W-1:0] pixel_out;

    // Write configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_mode <= MODE_NORMAL;
            r_opacity    <= OPACITY_FULL;
            r_key_enable <= 1'b0;
            r_key_colour <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BLEND_MODE: r_blend_mode <= i_cfg_data[1:0];
                REG_OPACITY:    r_opacity    <= i_cfg_data[7:0];
                REG_KEY_ENABLE: r_key_enable <= i_cfg_data[0];
                REG_KEY_COLOUR: r_key_colour <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Advance a stage when it is empty or the next one moves
    always_comb begin
        stage_en[4] = !r_valid[4] || i_out_ready;
        for (int k = 3; k >= 0; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k+1];
        end
        n_valid = r_valid;
        if (stage_en[0]) begin
            n_valid[0] = i_in_valid;
        end
        for (int k = 1; k < 5; k++) begin
            if (stage_en[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = stage_en[0];
    assign o_out_valid = r_valid[4];

    // Flag keyed foreground pixels and carry the flag down the pipe
    assign key_now = r_key_enable
                  && ({i_top_red, i_top_green, i_top_blue} == r_key_colour);

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_key_hit[0] <= key_now;
        end
        for (int k = 1; k < 4; k++) begin
            if (stage_en[k]) begin
                r_key_hit[k] <= r_key_hit[k-1];
            end
        end
    end

    assign lane_ctl.s1 = stage_en[0];
    assign lane_ctl.s2 = stage_en[1];
    assign lane_ctl.s3 = stage_en[2];
    assign lane_ctl.s4 = stage_en[3];

    assign base_in = {i_base_red, i_base_green, i_base_blue};
    assign top_in  = {i_top_red, i_top_green, i_top_blue};

    // One lane per color channel
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        pbm_lane u_lane (
            .i_clk        (i_clk),
            .i_ctl        (lane_ctl),
            .i_blend_mode (r_blend_mode),
            .i_opacity    (r_opacity),
            .i_base       (base_in[g]),
            .i_top        (top_in[g]),
            .o_lane       (lane_out[g])
        );
    end

    pbm_merge u_merge (
        .i_clk     (i_clk),
        .i_en      (stage_en[4]),
        .i_opacity (r_opacity),
        .i_key_hit (r_key_hit[3]),
        .i_lane    (lane_out),
        .o_pixel   (pixel_out)
    );

    assign o_out_red   = pixel_out[2];
    assign o_out_green = pixel_out[1];
    assign o_out_blue  = pixel_out[0];

endmodule
